FILE: sv/sll_pkg.sv
`default_nettype none

package sll_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;

  localparam int POS_W  = 10;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int STEP_W = 4;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // microcode addresses
  localparam logic [STEP_W-1:0] S_IDLE   = 4'd0;
  localparam logic [STEP_W-1:0] S_CHECK  = 4'd1;
  localparam logic [STEP_W-1:0] S_WCHK   = 4'd2;
  localparam logic [STEP_W-1:0] S_WALK   = 4'd3;
  localparam logic [STEP_W-1:0] S_AFTER  = 4'd4;
  localparam logic [STEP_W-1:0] S_INS0   = 4'd5;
  localparam logic [STEP_W-1:0] S_INS1   = 4'd6;
  localparam logic [STEP_W-1:0] S_INS2   = 4'd7;
  localparam logic [STEP_W-1:0] S_INS3   = 4'd8;
  localparam logic [STEP_W-1:0] S_DEL0   = 4'd9;
  localparam logic [STEP_W-1:0] S_DEL1   = 4'd10;
  localparam logic [STEP_W-1:0] S_DEL2   = 4'd11;
  localparam logic [STEP_W-1:0] S_DEL3   = 4'd12;
  localparam logic [STEP_W-1:0] S_ERR_RG = 4'd13;
  localparam logic [STEP_W-1:0] S_ERR_FL = 4'd14;

  typedef enum logic [1:0] {RA_CUR, RA_RDATA, RA_ZERO, RA_TMP} rd_sel_t;
  typedef enum logic [1:0] {WA_ZERO, WA_CUR, WA_SLOT} wa_sel_t;
  typedef enum logic [1:0] {WD_RDATA, WD_TMP, WD_SLOT} wd_sel_t;
  typedef enum logic {SL_RDATA, SL_TMP} slot_src_t;
  typedef enum logic [2:0] {
    J_NEVER, J_RANGE_ERR, J_WALK_ZERO, J_WALK_MORE, J_IS_DEL, J_FULL
  } jmp_sel_t;

  typedef struct packed {
    logic              rd_en;
    rd_sel_t           rd_sel;
    logic              wr_en;
    wa_sel_t           wa_sel;
    wd_sel_t           wd_sel;
    logic              ld_cur;
    logic              ld_slot;
    slot_src_t         slot_src;
    logic              ld_tmp;
    logic              wcnt_dec;
    logic              val_we;
    logic              cnt_inc;
    logic              cnt_dec;
    logic              finish;
    logic [STAT_W-1:0] fin_status;
    jmp_sel_t          jmp_sel;
    logic [STEP_W-1:0] target;
  } ctrl_word_t;

  typedef struct packed {
    logic range_err;
    logic walk_zero;
    logic walk_more;
    logic is_del;
    logic full;
  } cond_flags_t;

  // Control store. A read issued in one step shows up in rdata the next step.
  function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] addr);
    ctrl_word_t w;
    w = '0;
    case (addr)
      S_CHECK: begin
        w.rd_en = 1'b1;  w.rd_sel = RA_CUR;
        w.jmp_sel = J_RANGE_ERR;  w.target = S_ERR_RG;
      end
      S_WCHK: begin
        w.jmp_sel = J_WALK_ZERO;  w.target = S_AFTER;
      end
      S_WALK: begin
        // one hop a cycle: address straight from the read data
        w.ld_cur = 1'b1;  w.rd_en = 1'b1;  w.rd_sel = RA_RDATA;
        w.wcnt_dec = 1'b1;
        w.jmp_sel = J_WALK_MORE;  w.target = S_WALK;
      end
      S_AFTER: begin
        // rdata holds the predecessor's link here
        w.ld_tmp = 1'b1;  w.rd_en = 1'b1;  w.rd_sel = RA_ZERO;
        w.jmp_sel = J_IS_DEL;  w.target = S_DEL0;
      end
      S_INS0: begin
        w.ld_slot = 1'b1;  w.slot_src = SL_RDATA;
        w.rd_en = 1'b1;  w.rd_sel = RA_RDATA;
        w.jmp_sel = J_FULL;  w.target = S_ERR_FL;
      end
      S_INS1: begin
        w.wr_en = 1'b1;  w.wa_sel = WA_ZERO;  w.wd_sel = WD_RDATA;
        w.val_we = 1'b1;
      end
      S_INS2: begin
        w.wr_en = 1'b1;  w.wa_sel = WA_SLOT;  w.wd_sel = WD_TMP;
      end
      S_INS3: begin
        w.wr_en = 1'b1;  w.wa_sel = WA_CUR;  w.wd_sel = WD_SLOT;
        w.cnt_inc = 1'b1;  w.finish = 1'b1;  w.fin_status = ST_OK;
      end
      S_DEL0: begin
        w.ld_slot = 1'b1;  w.slot_src = SL_TMP;
        w.rd_en = 1'b1;  w.rd_sel = RA_TMP;
      end
      S_DEL1: begin
        w.wr_en = 1'b1;  w.wa_sel = WA_CUR;  w.wd_sel = WD_RDATA;
        w.rd_en = 1'b1;  w.rd_sel = RA_ZERO;
      end
      S_DEL2: begin
        w.wr_en = 1'b1;  w.wa_sel = WA_SLOT;  w.wd_sel = WD_RDATA;
      end
      S_DEL3: begin
        w.wr_en = 1'b1;  w.wa_sel = WA_ZERO;  w.wd_sel = WD_SLOT;
        w.cnt_dec = 1'b1;  w.finish = 1'b1;  w.fin_status = ST_OK;
      end
      S_ERR_RG: begin
        w.finish = 1'b1;  w.fin_status = ST_RANGE;
      end
      S_ERR_FL: begin
        w.finish = 1'b1;  w.fin_status = ST_FULL;
      end
      default: begin
        w = '0;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: sv/static_linked_list_engine.sv
`default_nettype none
// Linked list kept in a fixed link table. Slot 0 heads the free chain, the
// last slot heads the data chain, capacity is TABLE_DEPTH-2 elements.
// Input channel (item_valid / item_stall) carries opcode (insert or delete),
// a 1-based position and a value. Output channel (result_valid /
// result_stall) returns one beat per item: status, list length after the
// operation and the slot allocated or freed (0 on error).
// One item is worked at a time by a microcoded sequencer over a link memory
// with one read and one write port. The walk to the predecessor costs one
// memory read per cycle. The sequencer returns to idle between items.
// The result sits in an output register; a new item is accepted while it
// waits. If the receiver stalls, the next item runs up to its final step
// and holds there until the register frees.
// After reset a clearing pass over every entry rebuilds the link table,
// during which item_stall stays high.
module static_linked_list_engine
  import sll_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                item_valid,
  output logic               item_stall,
  input  wire                opcode,
  input  wire  [POS_W-1:0]   position,
  input  wire  [VAL_W-1:0]   value,
  output logic               result_valid,
  input  wire                result_stall,
  output logic [STAT_W-1:0]  status,
  output logic [POS_W-1:0]   list_length,
  output logic [POS_W-1:0]   slot_used
);

  localparam int LW = $clog2(TABLE_DEPTH);
  localparam int XW = LW + POS_W + 1;
  localparam logic [LW-1:0] HEAD = LW'(TABLE_DEPTH - 1);
  localparam logic [LW-1:0] CAP  = LW'(TABLE_DEPTH - 2);

  logic [LW-1:0]    link_mem [0:TABLE_DEPTH-1];
  logic [VAL_W-1:0] value_mem [0:TABLE_DEPTH-1];

  ctrl_word_t  cw;
  cond_flags_t flags;
  logic        seq_idle;
  logic        step_en;
  logic        start;
  logic        fin_fire;

  logic             op_r;
  logic [POS_W-1:0] pos_r;
  logic [VAL_W-1:0] val_r;
  logic [POS_W-1:0] wcnt;
  logic [LW-1:0]    cur;
  logic [LW-1:0]    slot;
  logic [LW-1:0]    tmp;
  logic [LW-1:0]    rdata;
  logic [LW-1:0]    count;
  logic [LW-1:0]    count_next;
  logic [LW-1:0]    ic;
  logic             init_busy;

  logic [LW-1:0]    rd_addr;
  logic [LW-1:0]    wr_addr;
  logic [LW-1:0]    wr_data;
  logic             mem_we;
  logic [XW-1:0]    pos_x;
  logic [XW-1:0]    lim_x;
  logic [LW+POS_W-1:0] slot_wide;
  logic [LW+POS_W-1:0] cnt_wide;

  sll_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .step_en (step_en),
    .flags   (flags),
    .cw      (cw),
    .idle    (seq_idle)
  );

  assign item_stall = init_busy || !seq_idle;
  assign start      = item_valid && !item_stall;
  // last step waits while the output register is full and stalled
  assign step_en    = !(cw.finish && result_valid && result_stall);
  assign fin_fire   = step_en && cw.finish;

  assign pos_x = XW'(pos_r);
  assign lim_x = (op_r == OP_DELETE) ? XW'(count) : XW'(count) + XW'(1);

  assign flags.range_err = (pos_r == '0) || (pos_x > lim_x);
  assign flags.walk_zero = (wcnt == '0);
  assign flags.walk_more = (wcnt != POS_W'(1));
  assign flags.is_del    = (op_r == OP_DELETE);
  assign flags.full      = (count >= CAP) || (rdata == '0);

  always_comb begin
    case (cw.rd_sel)
      RA_CUR:   rd_addr = cur;
      RA_RDATA: rd_addr = rdata;
      RA_ZERO:  rd_addr = '0;
      RA_TMP:   rd_addr = tmp;
      default:  rd_addr = '0;
    endcase
  end

  always_comb begin
    if (init_busy) begin
      wr_addr = ic;
      wr_data = (ic < CAP) ? LW'(ic + 1'b1) : '0;
    end else begin
      case (cw.wa_sel)
        WA_ZERO: wr_addr = '0;
        WA_CUR:  wr_addr = cur;
        WA_SLOT: wr_addr = slot;
        default: wr_addr = '0;
      endcase
      case (cw.wd_sel)
        WD_RDATA: wr_data = rdata;
        WD_TMP:   wr_data = tmp;
        WD_SLOT:  wr_data = slot;
        default:  wr_data = '0;
      endcase
    end
  end

  assign mem_we = init_busy || (step_en && cw.wr_en);

  always_ff @(posedge clk) begin
    if (mem_we) link_mem[wr_addr] <= wr_data;
    if (step_en && cw.rd_en) rdata <= link_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (step_en && cw.val_we) value_mem[slot] <= val_r;
  end

  // clearing pass: entry i links to i+1, free tail and list head end at 0
  always_ff @(posedge clk) begin
    if (rst) begin
      init_busy <= 1'b1;
      ic        <= '0;
    end else if (init_busy) begin
      if (ic == HEAD) init_busy <= 1'b0;
      ic <= ic + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op_r  <= opcode;
      pos_r <= position;
      val_r <= value;
      cur   <= HEAD;
      wcnt  <= position - 1'b1;
    end else if (step_en) begin
      if (cw.ld_cur)   cur  <= rdata;
      if (cw.wcnt_dec) wcnt <= wcnt - 1'b1;
    end
    if (step_en && cw.ld_slot) slot <= (cw.slot_src == SL_TMP) ? tmp : rdata;
    if (step_en && cw.ld_tmp)  tmp  <= rdata;
  end

  always_comb begin
    count_next = count;
    if (step_en && cw.cnt_inc) count_next = count + 1'b1;
    if (step_en && cw.cnt_dec) count_next = count - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) count <= '0;
    else     count <= count_next;
  end

  assign slot_wide = (LW + POS_W)'(slot);
  assign cnt_wide  = (LW + POS_W)'(count_next);

  always_ff @(posedge clk) begin
    if (rst)                result_valid <= 1'b0;
    else if (fin_fire)      result_valid <= 1'b1;
    else if (!result_stall) result_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (fin_fire) begin
      status      <= cw.fin_status;
      list_length <= cnt_wide[POS_W-1:0];
      slot_used   <= (cw.fin_status == ST_OK) ? slot_wide[POS_W-1:0] : '0;
    end
  end

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CAP)
    else $error("element count above capacity");

  a_err_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (fin_fire && cw.fin_status != ST_OK) |=> $stable(count))
    else $error("error result changed the element count");

  a_ok_slot: assert property (@(posedge clk) disable iff (rst)
    (fin_fire && cw.fin_status == ST_OK) |-> (slot != '0 && slot != HEAD))
    else $error("allocated or freed slot is a chain head");

  a_walk_cnt: assert property (@(posedge clk) disable iff (rst)
    (step_en && cw.wcnt_dec) |-> (wcnt != '0))
    else $error("walk ran past its hop count");

endmodule

`default_nettype wire

FILE: sv/sll_seq.sv
`default_nettype none

module sll_seq
  import sll_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  input  wire         step_en,
  input  cond_flags_t flags,
  output ctrl_word_t  cw,
  output logic        idle
);

  logic [STEP_W-1:0] upc;
  logic [STEP_W-1:0] upc_next;
  logic              jmp_take;

  assign cw   = ucode(upc);
  assign idle = (upc == S_IDLE);

  always_comb begin
    case (cw.jmp_sel)
      J_NEVER:     jmp_take = 1'b0;
      J_RANGE_ERR: jmp_take = flags.range_err;
      J_WALK_ZERO: jmp_take = flags.walk_zero;
      J_WALK_MORE: jmp_take = flags.walk_more;
      J_IS_DEL:    jmp_take = flags.is_del;
      J_FULL:      jmp_take = flags.full;
      default:     jmp_take = 1'b0;
    endcase
  end

  always_comb begin
    upc_next = upc;
    if (idle) begin
      if (start) upc_next = S_CHECK;
    end else if (step_en) begin
      if (cw.finish)     upc_next = S_IDLE;
      else if (jmp_take) upc_next = cw.target;
      else               upc_next = upc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) upc <= S_IDLE;
    else     upc <= upc_next;
  end

endmodule

`default_nettype wire
